@@ rtl/core/sbrp_pkg.sv @@
// shared types, constants and helpers for the stun binding response parser
package sbrp_pkg;

  // default datagram size limit in bytes
  localparam int MAX_DATAGRAM_DEF = 512;

  // header layout and protocol constants
  localparam int          HDR_BYTES          = 20;
  localparam logic [15:0] TYPE_BIND_RESPONSE = 16'h0101;
  localparam logic [31:0] MAGIC_VALUE        = 32'h2112A442;
  localparam logic [7:0]  FAMILY_V4          = 8'h01;
  localparam logic [15:0] ATTR_MAPPED        = 16'h0001;
  localparam logic [15:0] ATTR_XOR_MAPPED    = 16'h0020;
  localparam int          MIN_ADDR_VALUE_LEN = 8;

  // result status codes
  localparam logic [2:0] STATUS_OK         = 3'd0;
  localparam logic [2:0] STATUS_TRUNCATED  = 3'd1;
  localparam logic [2:0] STATUS_WRONG_TYPE = 3'd2;
  localparam logic [2:0] STATUS_BAD_COOKIE = 3'd3;
  localparam logic [2:0] STATUS_ID_MISMATCH = 3'd4;
  localparam logic [2:0] STATUS_NO_ADDRESS = 3'd5;

  // register indexes on the configuration port
  localparam logic REG_ID_HIGH = 1'b0;
  localparam logic REG_ID_LOW  = 1'b1;

  // one input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  // one result beat
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] public_address;
    logic [15:0] public_port;
    logic        was_xor_form;
  } out_t;

  // configured transaction id
  typedef struct packed {
    logic [31:0] id_high;
    logic [63:0] id_low;
  } cfg_t;

  // byte of the expected transaction id, index 0 to 11, big-endian
  function automatic logic [7:0] id_byte(input cfg_t cfg, input logic [3:0] idx);
    logic [95:0] full;
    logic [6:0]  sh;
    full = {cfg.id_high, cfg.id_low};
    sh   = 7'(4'd11 - idx) << 3;
    return 8'(full >> sh);
  endfunction

endpackage

@@ rtl/core/stun_binding_response_parser_core.sv @@
// top level of the stun binding response parser
//
// Datagram bytes enter on the rx channel (rx_valid, rx_stall, rx_beat),
// one byte per beat, last_byte marking the final byte of a datagram.
// One result beat per datagram leaves on the res channel (res_valid,
// res_stall, res_beat) with the status, the mapped address and port.
// The expected transaction id is set through the apb-style port:
// id_high at byte address 0, id_low at byte address 8, 64-bit data.
// Throughput is one byte per cycle while no final byte waits on
// res_stall; the parse step between the two registers is combinational.
// The result passes from the input register into the result register.
// When res_stall holds a pending result, non-final bytes still flow; a
// final byte waits in the input register until the result slot frees.
// Bytes past MAX_DATAGRAM are dropped but their end mark still counts.
// Synchronous reset clears all parse state, the id registers and the valid
// flags of both channel registers; no clearing pass is needed afterward.
module stun_binding_response_parser_core
  import sbrp_pkg::*;
#(
  parameter int MAX_DATAGRAM = MAX_DATAGRAM_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  in_t         rx_beat,
  output logic        res_valid,
  input  logic        res_stall,
  output out_t        res_beat,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  logic in_valid;
  in_t  in_item;
  logic out_free;
  logic go;
  logic step_valid;
  out_t step_res;

  sbrp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // a final byte advances only when the result slot can take it
  assign out_free = !res_valid || !res_stall;
  assign go       = in_valid && (!in_item.last_byte || out_free);
  assign rx_stall = in_valid && !go;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || go) begin
      in_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && !rx_stall) begin
      in_item <= rx_beat;
    end
  end

  sbrp_parse #(
    .MAX_DATAGRAM (MAX_DATAGRAM)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .item      (in_item),
    .cfg       (cfg),
    .res_valid (step_valid),
    .res       (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= step_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step_valid) begin
      res_beat <= step_res;
    end
  end

endmodule

@@ rtl/core/sbrp_cfg.sv @@
// configuration registers behind the apb-style port
module sbrp_cfg
  import sbrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic reg_idx;
  logic wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3];
  assign wr_en   = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.id_high <= '0;
      cfg.id_low  <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ID_HIGH: cfg.id_high <= pwdata[31:0];
        REG_ID_LOW:  cfg.id_low  <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_ID_HIGH: prdata = {32'd0, cfg.id_high};
      REG_ID_LOW:  prdata = cfg.id_low;
      default:     prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/sbrp_parse.sv @@
// per-byte header check and attribute walk, one byte per cycle while go is high
module sbrp_parse
  import sbrp_pkg::*;
#(
  parameter int MAX_DATAGRAM = MAX_DATAGRAM_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic go,
  input  in_t  item,
  input  cfg_t cfg,
  output logic res_valid,
  output out_t res
);

  localparam int POS_W = $clog2(MAX_DATAGRAM + 1);
  localparam int SUM_W = ((POS_W > 16) ? POS_W : 16) + 2;

  // parse state
  logic [POS_W-1:0] pos, pos_next;
  logic [2:0]       hdr_err, hdr_err_next;
  logic [15:0]      msg_len, msg_len_next;
  logic [31:0]      shift, shift_next;
  logic [POS_W-1:0] attr_start, attr_start_next;
  logic [15:0]      attr_type, attr_type_next;
  logic [15:0]      attr_len, attr_len_next;
  logic             stopped, stopped_next;
  logic             found, found_next;
  logic [31:0]      cand_addr, cand_addr_next;
  logic [15:0]      cand_port, cand_port_next;
  logic [SUM_W-1:0] cand_end, cand_end_next;
  logic             cand_xor, cand_xor_next;

  logic [31:0]      shift_new;
  logic [POS_W-1:0] r;
  logic [SUM_W-1:0] pad_end;
  logic [SUM_W-1:0] attr_end;
  logic [SUM_W-1:0] msg_end;
  logic             kept;
  logic             in_hdr;
  logic             cand_ok;
  logic [2:0]       status;

  assign shift_new = {shift[23:0], item.data_byte};
  assign kept      = pos < POS_W'(MAX_DATAGRAM);
  assign in_hdr    = pos < POS_W'(HDR_BYTES);
  assign r         = pos - attr_start;
  assign pad_end   = ((SUM_W'(attr_len) + SUM_W'(3)) & ~SUM_W'(3)) + SUM_W'(4);
  assign attr_end  = SUM_W'(attr_start) + SUM_W'(4) + SUM_W'(shift_new[15:0]);
  assign msg_end   = SUM_W'(HDR_BYTES) + SUM_W'(msg_len_next);

  // next state for one byte
  always_comb begin
    pos_next        = pos;
    hdr_err_next    = hdr_err;
    msg_len_next    = msg_len;
    shift_next      = shift;
    attr_start_next = attr_start;
    attr_type_next  = attr_type;
    attr_len_next   = attr_len;
    stopped_next    = stopped;
    found_next      = found;
    cand_addr_next  = cand_addr;
    cand_port_next  = cand_port;
    cand_end_next   = cand_end;
    cand_xor_next   = cand_xor;
    if (go && kept) begin
      shift_next = shift_new;
      pos_next   = pos + POS_W'(1);
      if (in_hdr) begin
        // header checks, first error sticks
        if (pos == POS_W'(1) && shift_new[15:0] != TYPE_BIND_RESPONSE && hdr_err == '0) begin
          hdr_err_next = STATUS_WRONG_TYPE;
        end
        if (pos == POS_W'(3)) begin
          msg_len_next = shift_new[15:0];
        end
        if (pos == POS_W'(7) && shift_new != MAGIC_VALUE && hdr_err == '0) begin
          hdr_err_next = STATUS_BAD_COOKIE;
        end
        if (pos >= POS_W'(8) && hdr_err == '0 &&
            item.data_byte != id_byte(cfg, 4'(pos - POS_W'(8)))) begin
          hdr_err_next = STATUS_ID_MISMATCH;
        end
        if (pos == POS_W'(HDR_BYTES - 1)) begin
          attr_start_next = POS_W'(HDR_BYTES);
        end
      end else if (!stopped) begin
        // attribute walk
        if (r >= POS_W'(4) && SUM_W'(r) == pad_end) begin
          attr_start_next = pos;
        end else if (r == POS_W'(1)) begin
          attr_type_next = shift_new[15:0];
        end else if (r == POS_W'(3)) begin
          attr_len_next = shift_new[15:0];
          if (attr_end > SUM_W'(HDR_BYTES) + SUM_W'(msg_len)) begin
            stopped_next = 1'b1;
          end
          if (shift_new[15:0] < 16'(MIN_ADDR_VALUE_LEN)) begin
            attr_type_next = '0;
          end
        end else if (r == POS_W'(5)) begin
          if (item.data_byte != FAMILY_V4) begin
            attr_type_next = '0;
          end
        end else if (r == POS_W'(7)) begin
          if (!found) begin
            cand_port_next = shift_new[15:0];
          end
        end else if (r == POS_W'(11)) begin
          if (!found && (attr_type == ATTR_MAPPED || attr_type == ATTR_XOR_MAPPED)) begin
            found_next     = 1'b1;
            cand_xor_next  = attr_type == ATTR_XOR_MAPPED;
            cand_end_next  = SUM_W'(attr_start) + SUM_W'(4) + SUM_W'(attr_len);
            if (attr_type == ATTR_XOR_MAPPED) begin
              cand_addr_next = shift_new ^ MAGIC_VALUE;
              cand_port_next = cand_port ^ MAGIC_VALUE[31:16];
            end else begin
              cand_addr_next = shift_new;
            end
          end
        end
      end
    end
  end

  // final status from the updated state
  assign cand_ok = found_next && cand_end_next <= msg_end &&
                   cand_end_next <= SUM_W'(pos_next);

  always_comb begin
    if (pos_next < POS_W'(HDR_BYTES)) begin
      status = STATUS_TRUNCATED;
    end else if (hdr_err_next != '0) begin
      status = hdr_err_next;
    end else if (cand_ok) begin
      status = STATUS_OK;
    end else begin
      status = STATUS_NO_ADDRESS;
    end
  end

  assign res_valid = go && item.last_byte;

  always_comb begin
    res.status         = status;
    res.public_address = (status == STATUS_OK) ? cand_addr_next : '0;
    res.public_port    = (status == STATUS_OK) ? cand_port_next : '0;
    res.was_xor_form   = (status == STATUS_OK) && cand_xor_next;
  end

  // state registers, cleared at reset and after each datagram
  always_ff @(posedge clk) begin
    if (rst || res_valid) begin
      pos        <= '0;
      hdr_err    <= '0;
      msg_len    <= '0;
      shift      <= '0;
      attr_start <= '0;
      attr_type  <= '0;
      attr_len   <= '0;
      stopped    <= 1'b0;
      found      <= 1'b0;
      cand_addr  <= '0;
      cand_port  <= '0;
      cand_end   <= '0;
      cand_xor   <= 1'b0;
    end else begin
      pos        <= pos_next;
      hdr_err    <= hdr_err_next;
      msg_len    <= msg_len_next;
      shift      <= shift_next;
      attr_start <= attr_start_next;
      attr_type  <= attr_type_next;
      attr_len   <= attr_len_next;
      stopped    <= stopped_next;
      found      <= found_next;
      cand_addr  <= cand_addr_next;
      cand_port  <= cand_port_next;
      cand_end   <= cand_end_next;
      cand_xor   <= cand_xor_next;
    end
  end

endmodule
